// ----- rtl/text_chunk_boundary_finder_defines.svh -----
`ifndef TEXT_CHUNK_BOUNDARY_FINDER_DEFINES_SVH
`define TEXT_CHUNK_BOUNDARY_FINDER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define TCBF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tcbf: same-cycle check failed");

// next-cycle implication, clocked on aclk, off during reset
`define TCBF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tcbf: next-cycle check failed");

`endif

// ----- rtl/tcbf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcbf_pkg;

    localparam int OFFSET_BITS_DEFAULT = 17;
    localparam int LEN_W               = 17;
    localparam int QUEUE_DEPTH         = 2;
    localparam int PADDR_W             = 3;
    localparam int PDATA_W             = 32;

    localparam logic [7:0]  NEWLINE_BYTE    = 8'h0A;
    localparam logic [7:0]  SPACE_BYTE      = 8'h20;
    localparam logic [15:0] MAX_CHARS_RESET = 16'd4096;
    localparam logic [15:0] MIN_CHARS       = 16'd2;

    localparam logic REG_MAX_CHARS = 1'b0;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       no_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] chunk_length;
        logic             final_chunk;
    } out_item_t;

    typedef struct packed {
        logic has_byte;
        logic is_newline;
        logic is_space;
        logic end_of_text;
    } cls_item_t;

    typedef enum logic [1:0] {
        SEQ_RUN,
        SEQ_END_CUT,
        SEQ_END_FIN
    } seq_state_t;

    typedef struct packed {
        seq_state_t state;
        logic       hold_valid;
    } back_status_t;

endpackage

`default_nettype wire

// ----- rtl/tcbf_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcbf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tcbf_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcbf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcbf_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tcbf_pkg::in_item_t   s_data,
    output tcbf_pkg::cls_item_t       q_item,
    output logic                      q_empty,
    input  wire logic                 q_pop
);

    tcbf_pkg::cls_item_t cls;
    logic                q_full;
    logic                q_push;

    always_comb begin
        cls.has_byte    = !s_data.no_byte;
        cls.is_newline  = !s_data.no_byte && (s_data.text_byte == tcbf_pkg::NEWLINE_BYTE);
        cls.is_space    = !s_data.no_byte && (s_data.text_byte == tcbf_pkg::SPACE_BYTE);
        cls.end_of_text = s_data.end_of_text;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    tcbf_fifo #(
        .WIDTH ($bits(tcbf_pkg::cls_item_t)),
        .DEPTH (tcbf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (cls),
        .pop     (q_pop),
        .rd_data (q_item),
        .full    (q_full),
        .empty   (q_empty)
    );

endmodule

`default_nettype wire

// ----- rtl/tcbf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcbf_back #(
    parameter int OFFSET_BITS = tcbf_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  clear,
    input  wire logic [15:0]           max_chars,
    input  wire tcbf_pkg::cls_item_t   item,
    input  wire logic                  item_valid,
    output logic                       item_pop,
    input  wire logic                  out_full,
    output logic                       out_push,
    output tcbf_pkg::out_item_t        out_item,
    output tcbf_pkg::back_status_t     status
);

    localparam int CW = (OFFSET_BITS > tcbf_pkg::LEN_W) ? OFFSET_BITS : tcbf_pkg::LEN_W;

    typedef logic [OFFSET_BITS-1:0] off_t;

    typedef struct packed {
        off_t pc;
        off_t bl_off;
        logic bl_seen;
        off_t nl_off;
        logic nl_seen;
        off_t sp_off;
        logic sp_seen;
        logic prev_nl;
    } text_t;

    function automatic text_t add_byte(text_t t, logic nl, logic sp);
        text_t r;
        r = t;
        if (nl) begin
            if (t.prev_nl && (t.pc != '0)) begin
                r.bl_off  = t.pc - off_t'(1);
                r.bl_seen = 1'b1;
            end
            r.nl_off  = t.pc;
            r.nl_seen = 1'b1;
        end else if (sp) begin
            r.sp_off  = t.pc;
            r.sp_seen = 1'b1;
        end
        r.prev_nl = nl;
        r.pc      = t.pc + off_t'(1);
        return r;
    endfunction

    function automatic text_t drop(text_t t, off_t len);
        text_t r;
        r      = t;
        r.pc   = (t.pc >= len) ? t.pc - len : '0;
        if (t.bl_seen && (t.bl_off >= len)) begin
            r.bl_off = t.bl_off - len;
        end else begin
            r.bl_off  = '0;
            r.bl_seen = 1'b0;
        end
        if (t.nl_seen && (t.nl_off >= len)) begin
            r.nl_off = t.nl_off - len;
        end else begin
            r.nl_off  = '0;
            r.nl_seen = 1'b0;
        end
        if (t.sp_seen && (t.sp_off >= len)) begin
            r.sp_off = t.sp_off - len;
        end else begin
            r.sp_off  = '0;
            r.sp_seen = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [tcbf_pkg::LEN_W-1:0] to_len(off_t v);
        logic [CW-1:0] e;
        e = CW'(v);
        return e[tcbf_pkg::LEN_W-1:0];
    endfunction

    tcbf_pkg::seq_state_t state_reg;
    tcbf_pkg::seq_state_t state_next;
    text_t                text_reg;
    text_t                text_next;
    text_t                added;
    logic                 hold_valid_reg;
    logic                 hold_valid_next;
    off_t                 hold_len_reg;
    off_t                 hold_len_next;

    logic [15:0]   limit;
    logic [CW-1:0] m_ext;
    logic [CW-1:0] half_ext;
    logic          over;
    off_t          base_len;
    off_t          pair_len;
    off_t          cut_len;
    logic          advance;

    always_comb begin
        limit    = (max_chars < tcbf_pkg::MIN_CHARS) ? tcbf_pkg::MIN_CHARS : max_chars;
        m_ext    = CW'(limit);
        half_ext = CW'(limit >> 1);
        over     = CW'(text_reg.pc) > m_ext;
        pair_len = OFFSET_BITS'(m_ext + CW'(2));
        if (text_reg.bl_seen && (CW'(text_reg.bl_off) > half_ext)) begin
            base_len = text_reg.bl_off + off_t'(2);
        end else if (text_reg.nl_seen && (CW'(text_reg.nl_off) > half_ext)) begin
            base_len = text_reg.nl_off + off_t'(1);
        end else if (text_reg.sp_seen && (CW'(text_reg.sp_off) > half_ext)) begin
            base_len = text_reg.sp_off + off_t'(1);
        end else begin
            base_len = OFFSET_BITS'(m_ext);
        end
        cut_len = (item.is_newline && text_reg.prev_nl) ? pair_len : base_len;
        added   = add_byte(text_reg, item.is_newline, item.is_space);
    end

    assign advance = !out_full;

    always_comb begin
        state_next      = state_reg;
        text_next       = text_reg;
        hold_valid_next = hold_valid_reg;
        hold_len_next   = hold_len_reg;
        item_pop        = 1'b0;
        out_push        = 1'b0;
        out_item        = '0;
        unique case (state_reg)
            tcbf_pkg::SEQ_RUN: begin
                if (item_valid && advance) begin
                    item_pop        = 1'b1;
                    hold_valid_next = 1'b0;
                    if (item.has_byte) begin
                        text_next = over ? drop(added, cut_len) : added;
                        if (item.end_of_text) begin
                            hold_valid_next = over;
                            hold_len_next   = cut_len;
                        end else if (over) begin
                            out_push              = 1'b1;
                            out_item.chunk_length = to_len(cut_len);
                        end
                    end
                    if (item.end_of_text) begin
                        state_next = tcbf_pkg::SEQ_END_CUT;
                    end
                end
            end
            tcbf_pkg::SEQ_END_CUT: begin
                if (advance) begin
                    if (over) begin
                        text_next = drop(text_reg, base_len);
                        if (hold_valid_reg) begin
                            out_push              = 1'b1;
                            out_item.chunk_length = to_len(hold_len_reg);
                        end
                        hold_valid_next = 1'b1;
                        hold_len_next   = base_len;
                    end
                    state_next = tcbf_pkg::SEQ_END_FIN;
                end
            end
            tcbf_pkg::SEQ_END_FIN: begin
                if (advance) begin
                    if ((text_reg.pc != '0) && hold_valid_reg) begin
                        out_push              = 1'b1;
                        out_item.chunk_length = to_len(hold_len_reg);
                        hold_valid_next       = 1'b0;
                    end else begin
                        if (text_reg.pc != '0) begin
                            out_push              = 1'b1;
                            out_item.chunk_length = to_len(text_reg.pc);
                            out_item.final_chunk  = 1'b1;
                        end else if (hold_valid_reg) begin
                            out_push              = 1'b1;
                            out_item.chunk_length = to_len(hold_len_reg);
                            out_item.final_chunk  = 1'b1;
                        end
                        text_next       = '0;
                        hold_valid_next = 1'b0;
                        state_next      = tcbf_pkg::SEQ_RUN;
                    end
                end
            end
            default: begin
                state_next = tcbf_pkg::SEQ_RUN;
            end
        endcase
        if (clear) begin
            state_next      = tcbf_pkg::SEQ_RUN;
            text_next       = '0;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tcbf_pkg::SEQ_RUN;
            text_reg       <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            text_reg       <= text_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_len_reg <= hold_len_next;
    end

    assign status.state      = state_reg;
    assign status.hold_valid = hold_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/text_chunk_boundary_finder.sv -----
// Path: text bytes are registered in the input queue and chunks in the output queue;
// end-of-text results are pushed from the final state, after the end cut.
// Throughput: one text byte per cycle while the output queue has room; an
// end-of-text item then runs the end cut and one or two result steps.
// Reset: synchronous, active-low aresetn; max_chars returns to 4096 and all
// pending-chunk state clears. A max_chars write also clears the pending chunk.
`timescale 1ns / 1ps
`default_nettype none

`include "text_chunk_boundary_finder_defines.svh"

module text_chunk_boundary_finder #(
    parameter int OFFSET_BITS = tcbf_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire tcbf_pkg::in_item_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output tcbf_pkg::out_item_t                m_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcbf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tcbf_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tcbf_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    logic [15:0] max_chars_reg;
    logic [15:0] max_chars_next;
    logic        reg_sel;
    logic        cfg_write;

    tcbf_pkg::cls_item_t    in_item;
    logic                   in_empty;
    logic                   in_pop;
    logic                   out_push;
    logic                   out_full;
    logic                   out_empty;
    tcbf_pkg::out_item_t    out_item;
    tcbf_pkg::back_status_t back_status;
    logic                   back_run;

    assign pready    = 1'b1;
    assign reg_sel   = (paddr[tcbf_pkg::PADDR_W-1:2] == tcbf_pkg::REG_MAX_CHARS);
    assign cfg_write = psel && penable && pwrite && reg_sel;

    always_comb begin
        max_chars_next = max_chars_reg;
        if (cfg_write) begin
            max_chars_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg <= tcbf_pkg::MAX_CHARS_RESET;
        end else begin
            max_chars_reg <= max_chars_next;
        end
    end

    assign prdata = reg_sel ? tcbf_pkg::PDATA_W'(max_chars_reg) : '0;

    tcbf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_item  (in_item),
        .q_empty (in_empty),
        .q_pop   (in_pop)
    );

    tcbf_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (cfg_write),
        .max_chars  (max_chars_reg),
        .item       (in_item),
        .item_valid (!in_empty),
        .item_pop   (in_pop),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_item   (out_item),
        .status     (back_status)
    );

    tcbf_fifo #(
        .WIDTH ($bits(tcbf_pkg::out_item_t)),
        .DEPTH (tcbf_pkg::QUEUE_DEPTH)
    ) u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (out_push),
        .wr_data (out_item),
        .pop     (m_ready),
        .rd_data (m_data),
        .full    (out_full),
        .empty   (out_empty)
    );

    assign m_valid  = !out_empty;
    assign back_run = (back_status.state == tcbf_pkg::SEQ_RUN);

    `TCBF_ASSERT_IMP(a_out_no_overflow, out_push, !out_full)
    `TCBF_ASSERT_IMP(a_pop_nonempty, in_pop, !in_empty)
    `TCBF_ASSERT_NEXT(a_final_to_run, out_push && out_item.final_chunk, back_run)
    `TCBF_ASSERT_IMP(a_run_no_hold, back_run, !back_status.hold_valid)

endmodule

`default_nettype wire
